FILE: rtl/core/phsm_pkg.sv
// phsm_pkg: shared types and constants for the particle height splat block
// no dependencies; imported by every module of the block

package phsm_pkg;

    // largest texel address width over the supported texture sizes (4096 x 4096)
    localparam int IDX_W = 24;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

    localparam logic [30:0] RADIUS_RESET = 31'd1024;

    localparam logic OP_SPLAT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // height byte is -100 * z with z in Q22.10
    localparam int HEIGHT_SCALE = 100;
    localparam int FRAC_BITS    = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [30:0] radius;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_MISS,
        CMD_HIT,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic             blank;
        logic [IDX_W-1:0] index;
        logic [7:0]       height;
    } cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIFF,
        F_MUL,
        F_CMP,
        F_DIV,
        F_IDX,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_UPD
    } back_state_t;

endpackage

FILE: rtl/core/phsm_cfg.sv
// phsm_cfg: apb-style register file holding origin and radius
// depends on phsm_pkg

module phsm_cfg import phsm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [31:0] origin_x_reg;
    logic [31:0] origin_y_reg;
    logic [30:0] radius_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            radius_reg   <= RADIUS_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ORIGIN_X: origin_x_reg <= pwdata;
                REG_ORIGIN_Y: origin_y_reg <= pwdata;
                REG_RADIUS:   radius_reg   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ORIGIN_X: prdata = origin_x_reg;
            REG_ORIGIN_Y: prdata = origin_y_reg;
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.origin_x = origin_x_reg;
    assign cfg.origin_y = origin_y_reg;
    assign cfg.radius   = radius_reg;

endmodule

FILE: rtl/core/phsm_front.sv
// phsm_front: accepts requests, tests the radius, scales to texels, builds commands
// depends on phsm_pkg; feeds phsm_queue

module phsm_front import phsm_pkg::*; #(
    parameter int TEX_WIDTH  = 256,
    parameter int TEX_HEIGHT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        clear_busy,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_particle_x,
    input  logic [31:0] s_particle_y,
    input  logic [31:0] s_particle_z,
    input  logic [15:0] s_read_index,
    output logic        push_valid,
    input  logic        push_ready,
    output cmd_t        push_cmd
);

    localparam int MAX_SIZE    = (TEX_WIDTH > TEX_HEIGHT) ? TEX_WIDTH : TEX_HEIGHT;
    localparam int QW          = $clog2(MAX_SIZE);
    localparam int SZW         = $clog2(MAX_SIZE + 1);
    localparam int PW          = 32 + SZW;
    localparam int CW          = $clog2(QW + 1);
    localparam int TEXEL_COUNT = TEX_WIDTH * TEX_HEIGHT;

    front_state_t state_reg, state_next;

    logic [31:0]   px_reg, py_reg, pz_reg;
    logic [31:0]   px_next, py_next, pz_next;
    logic          near_reg, near_next;
    logic [30:0]   ux_reg, uy_reg, ux_next, uy_next;
    logic [31:0]   shx_reg, shy_reg, shx_next, shy_next;
    logic [7:0]    hgt_reg, hgt_next;
    logic [61:0]   sqx_reg, sqy_reg, rr_reg, sqx_next, sqy_next, rr_next;
    logic [PW-1:0] prx_reg, pry_reg, prx_next, pry_next;
    logic [31:0]   remx_reg, remy_reg, remx_next, remy_next;
    logic [QW-1:0] lowx_reg, lowy_reg, lowx_next, lowy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    cmd_t          cmd_reg, cmd_next;

    logic signed [32:0] dx, dy, shx_full, shy_full, rad_s;
    logic [32:0]        ux, uy, rad_u;
    logic [31:0]        zmag;
    logic [39:0]        hprod;
    logic [29:0]        hq;
    logic [62:0]        sq_sum;
    logic [31:0]        dvs;
    logic [32:0]        tx2, ty2;
    logic               gex, gey;

    assign rad_u = {2'b00, cfg.radius};
    assign rad_s = $signed(rad_u);
    assign dvs   = {cfg.radius, 1'b0};

    // planar offset, magnitude and shifted offset; scaled height, squared-distance sum and divider compare
    always_comb begin
        dx       = 33'($signed(px_reg)) - 33'($signed(cfg.origin_x));
        dy       = 33'($signed(py_reg)) - 33'($signed(cfg.origin_y));
        ux       = dx[32] ? 33'(-dx) : 33'(dx);
        uy       = dy[32] ? 33'(-dy) : 33'(dy);
        shx_full = dx + rad_s;
        shy_full = dy + rad_s;
        zmag     = 32'(-33'($signed(pz_reg)));
        hprod    = 40'(zmag) * 40'(HEIGHT_SCALE);
        hq       = hprod[39:FRAC_BITS];
        sq_sum   = 63'(sqx_reg) + 63'(sqy_reg);
        tx2      = {remx_reg, lowx_reg[QW-1]};
        ty2      = {remy_reg, lowy_reg[QW-1]};
        gex      = tx2 >= {1'b0, dvs};
        gey      = ty2 >= {1'b0, dvs};
    end

    always_comb begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        near_next  = near_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        shx_next   = shx_reg;
        shy_next   = shy_reg;
        hgt_next   = hgt_reg;
        sqx_next   = sqx_reg;
        sqy_next   = sqy_reg;
        rr_next    = rr_reg;
        prx_next   = prx_reg;
        pry_next   = pry_reg;
        remx_next  = remx_reg;
        remy_next  = remy_reg;
        lowx_next  = lowx_reg;
        lowy_next  = lowy_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        s_ready    = 1'b0;
        push_valid = 1'b0;
        case (state_reg)
            F_IDLE: begin
                s_ready = !clear_busy;
                if (s_valid && !clear_busy) begin
                    px_next = s_particle_x;
                    py_next = s_particle_y;
                    pz_next = s_particle_z;
                    if (s_operation == OP_READ) begin
                        cmd_next.kind   = CMD_READ;
                        cmd_next.blank  = 32'(s_read_index) >= 32'(TEXEL_COUNT);
                        cmd_next.index  = IDX_W'(s_read_index);
                        cmd_next.height = '0;
                        state_next      = F_PUSH;
                    end else begin
                        state_next = F_DIFF;
                    end
                end
            end
            F_DIFF: begin
                near_next = (ux < rad_u) && (uy < rad_u);
                ux_next   = ux[30:0];
                uy_next   = uy[30:0];
                shx_next  = shx_full[31:0];
                shy_next  = shy_full[31:0];
                if (!pz_reg[31]) begin
                    hgt_next = '0;
                end else if (hq > 30'd255) begin
                    hgt_next = 8'hff;
                end else begin
                    hgt_next = hq[7:0];
                end
                state_next = F_MUL;
            end
            F_MUL: begin
                sqx_next   = 62'(ux_reg) * 62'(ux_reg);
                sqy_next   = 62'(uy_reg) * 62'(uy_reg);
                rr_next    = 62'(cfg.radius) * 62'(cfg.radius);
                prx_next   = PW'(shx_reg) * PW'(TEX_WIDTH);
                pry_next   = PW'(shy_reg) * PW'(TEX_HEIGHT);
                state_next = F_CMP;
            end
            F_CMP: begin
                if (near_reg && (sq_sum < 63'(rr_reg))) begin
                    remx_next  = 32'(prx_reg >> QW);
                    remy_next  = 32'(pry_reg >> QW);
                    lowx_next  = prx_reg[QW-1:0];
                    lowy_next  = pry_reg[QW-1:0];
                    cnt_next   = CW'(QW - 1);
                    state_next = F_DIV;
                end else begin
                    cmd_next.kind   = CMD_MISS;
                    cmd_next.blank  = 1'b1;
                    cmd_next.index  = '0;
                    cmd_next.height = '0;
                    state_next      = F_PUSH;
                end
            end
            F_DIV: begin
                // restoring division, one quotient bit per axis per cycle
                remx_next = gex ? 32'(tx2 - {1'b0, dvs}) : tx2[31:0];
                remy_next = gey ? 32'(ty2 - {1'b0, dvs}) : ty2[31:0];
                lowx_next = (lowx_reg << 1) | QW'(gex);
                lowy_next = (lowy_reg << 1) | QW'(gey);
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = F_IDX;
                end
            end
            F_IDX: begin
                cmd_next.kind   = CMD_HIT;
                cmd_next.blank  = 1'b0;
                cmd_next.index  = IDX_W'(lowx_reg) + IDX_W'(lowy_reg) * IDX_W'(TEX_WIDTH);
                cmd_next.height = hgt_reg;
                state_next      = F_PUSH;
            end
            F_PUSH: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign push_cmd = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        near_reg <= near_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        shx_reg  <= shx_next;
        shy_reg  <= shy_next;
        hgt_reg  <= hgt_next;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        rr_reg   <= rr_next;
        prx_reg  <= prx_next;
        pry_reg  <= pry_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        lowx_reg <= lowx_next;
        lowy_reg <= lowy_next;
        cnt_reg  <= cnt_next;
        cmd_reg  <= cmd_next;
    end

endmodule

FILE: rtl/core/phsm_queue.sv
// phsm_queue: short command queue between front and back
// depends on phsm_pkg

module phsm_queue import phsm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/phsm_back.sv
// phsm_back: texel store, clearing pass, read-modify-write and result register
// depends on phsm_pkg; fed by phsm_queue

module phsm_back import phsm_pkg::*; #(
    parameter int TEX_WIDTH  = 256,
    parameter int TEX_HEIGHT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        clear_busy,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [15:0] m_texel_index,
    output logic [7:0]  m_texel_value
);

    localparam int DEPTH = TEX_WIDTH * TEX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    back_state_t state_reg, state_next;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] clr_reg, clr_next;
    cmd_t          cur_reg, cur_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_hit_reg, m_hit_next;
    logic [15:0]   m_index_reg, m_index_next;
    logic [7:0]    m_value_reg, m_value_next;

    logic [AW-1:0] raddr, waddr;
    logic [7:0]    wdata;
    logic          we;
    logic          out_free;
    logic [7:0]    upd_value;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (cur_reg.kind)
            CMD_HIT:  upd_value = (cur_reg.height > rdata_reg) ? cur_reg.height : rdata_reg;
            CMD_READ: upd_value = cur_reg.blank ? 8'd0 : rdata_reg;
            default:  upd_value = 8'd0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_hit_next   = m_hit_reg;
        m_index_next = m_index_reg;
        m_value_next = m_value_reg;
        q_ready      = 1'b0;
        raddr        = cur_reg.index[AW-1:0];
        we           = 1'b0;
        waddr        = cur_reg.index[AW-1:0];
        wdata        = upd_value;
        case (state_reg)
            B_CLEAR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = 8'd0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                q_ready = 1'b1;
                raddr   = q_cmd.index[AW-1:0];
                if (q_valid) begin
                    cur_next   = q_cmd;
                    state_next = B_UPD;
                end
            end
            B_UPD: begin
                if (out_free) begin
                    we           = cur_reg.kind == CMD_HIT;
                    m_valid_next = 1'b1;
                    m_hit_next   = cur_reg.kind == CMD_HIT;
                    m_index_next = cur_reg.index[15:0];
                    m_value_next = upd_value;
                    state_next   = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        m_hit_reg   <= m_hit_next;
        m_index_reg <= m_index_next;
        m_value_reg <= m_value_next;
    end

    assign clear_busy    = state_reg == B_CLEAR;
    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_texel_index = m_index_reg;
    assign m_texel_value = m_value_reg;

endmodule

FILE: rtl/core/particle_height_splat_max_top.sv
// particle_height_splat_max_top: particle height splatting into a max texture
// depends on phsm_pkg, phsm_cfg, phsm_front, phsm_queue, phsm_back
// read: the front passes from accepting the request straight to pushing its command
// splat inside the radius: the front passes through its difference, multiply, compare, divide
// and index states before the push, the texel divider giving one quotient bit per cycle
// splat outside the radius: the front goes from the compare state straight to the push
// reset clears the control registers, then the clearing pass over every texel holds s_ready low

module particle_height_splat_max_top import phsm_pkg::*; #(
    parameter int TEX_WIDTH  = 256,
    parameter int TEX_HEIGHT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [31:0]           s_particle_x,
    input  logic [31:0]           s_particle_y,
    input  logic [31:0]           s_particle_z,
    input  logic [15:0]           s_read_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [15:0]           m_texel_index,
    output logic [7:0]            m_texel_value
);

    cfg_t cfg;
    logic clear_busy;
    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;

    phsm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    phsm_front #(
        .TEX_WIDTH  (TEX_WIDTH),
        .TEX_HEIGHT (TEX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .clear_busy   (clear_busy),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_particle_x (s_particle_x),
        .s_particle_y (s_particle_y),
        .s_particle_z (s_particle_z),
        .s_read_index (s_read_index),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    phsm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    phsm_back #(
        .TEX_WIDTH  (TEX_WIDTH),
        .TEX_HEIGHT (TEX_HEIGHT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (pop_valid),
        .q_ready       (pop_ready),
        .q_cmd         (pop_cmd),
        .clear_busy    (clear_busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_texel_index (m_texel_index),
        .m_texel_value (m_texel_value)
    );

endmodule

FILE: verif/height_texel_checker.sv
// height_texel_checker: watches the request, result and register channels of the splat block,
// predicts every result from its own copy of the height texture and compares them in order
// depends on phsm_pkg for the opcode and register index constants
`timescale 1ns / 100ps

module height_texel_checker import phsm_pkg::*; #(
    parameter int TEX_WIDTH  = 256,
    parameter int TEX_HEIGHT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_operation,
    input  logic [31:0]           s_particle_x,
    input  logic [31:0]           s_particle_y,
    input  logic [31:0]           s_particle_z,
    input  logic [15:0]           s_read_index,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_hit,
    input  logic [15:0]           m_texel_index,
    input  logic [7:0]            m_texel_value,
    output int                    failures,
    output int                    outstanding
);

    localparam int TEXEL_COUNT = TEX_WIDTH * TEX_HEIGHT;

    typedef struct packed {
        logic        hit;
        logic [15:0] index;
        logic [7:0]  value;
    } texel_result_t;

    logic [7:0]    texels [TEXEL_COUNT];
    logic [31:0]   cfg_origin_x;
    logic [31:0]   cfg_origin_y;
    logic [30:0]   cfg_radius;
    texel_result_t awaited_texels [$];

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (failures < 40)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        failures++;
    endtask

    function automatic longint unsigned axis_cell(longint d, longint unsigned r,
                                                  longint unsigned size);
        longint unsigned t;
        t = ($unsigned(d + longint'(r)) * size) / (2 * r);
        return (t < size) ? t : size - 1;
    endfunction

    function automatic texel_result_t predict_texel(logic op, logic [31:0] px, logic [31:0] py,
                                                    logic [31:0] pz, logic [15:0] ridx);
        texel_result_t   res;
        longint          dx, dy, depth;
        longint unsigned r, ux, uy, tx, ty, tidx, hgt;
        res = '0;
        if (op == OP_READ) begin
            res.index = ridx;
            if (ridx < TEXEL_COUNT)
                res.value = texels[ridx];
            return res;
        end
        r  = 64'(cfg_radius);
        dx = longint'($signed(px)) - longint'($signed(cfg_origin_x));
        dy = longint'($signed(py)) - longint'($signed(cfg_origin_y));
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        if (ux >= r || uy >= r)
            return res;
        if (ux * ux + uy * uy >= r * r)
            return res;
        tx    = axis_cell(dx, r, 64'(TEX_WIDTH));
        ty    = axis_cell(dy, r, 64'(TEX_HEIGHT));
        tidx  = tx + 64'(TEX_WIDTH) * ty;
        depth = -100 * longint'($signed(pz));
        if (depth <= 0) begin
            hgt = 0;
        end else begin
            hgt = $unsigned(depth) >> FRAC_BITS;
            if (hgt > 255)
                hgt = 255;
        end
        if (hgt > texels[tidx])
            texels[tidx] = hgt[7:0];
        res.hit   = 1'b1;
        res.index = tidx[15:0];
        res.value = texels[tidx];
        return res;
    endfunction

    always @(posedge aclk) begin
        texel_result_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < TEXEL_COUNT; i++)
                texels[i] = '0;
            cfg_origin_x = '0;
            cfg_origin_y = '0;
            cfg_radius   = RADIUS_RESET;
            awaited_texels.delete();
            failures     = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ORIGIN_X: cfg_origin_x = pwdata;
                    REG_ORIGIN_Y: cfg_origin_y = pwdata;
                    REG_RADIUS:   cfg_radius   = pwdata[30:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = '{m_hit, m_texel_index, m_texel_value};
                if (awaited_texels.size() == 0) begin
                    report_mismatch("result with no request waiting, index", got.index, 0);
                end else begin
                    want = awaited_texels.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", got.hit, want.hit);
                    if (got.index !== want.index)
                        report_mismatch("texel_index", got.index, want.index);
                    if (got.value !== want.value)
                        report_mismatch("texel_value", got.value, want.value);
                end
            end
            if (s_valid && s_ready)
                awaited_texels.insert(awaited_texels.size(),
                                      predict_texel(s_operation, s_particle_x, s_particle_y,
                                                    s_particle_z, s_read_index));
        end
        outstanding <= awaited_texels.size();
    end

endmodule

FILE: verif/tb.sv
// tb: drives particle splat and texel read requests into the splat block with random gaps
// and stalls, reprogramming the texture area between phases; needs phsm_pkg, the block's rtl
// and height_texel_checker, which predicts and compares every result
`timescale 1ns / 100ps

module tb;
    import phsm_pkg::*;

    localparam int TEX_WIDTH  = 256;
    localparam int TEX_HEIGHT = 256;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_operation  = OP_SPLAT;
    logic [31:0]           s_particle_x = '0;
    logic [31:0]           s_particle_y = '0;
    logic [31:0]           s_particle_z = '0;
    logic [15:0]           s_read_index = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b1;
    logic                  m_hit;
    logic [15:0]           m_texel_index;
    logic [7:0]            m_texel_value;
    int                    failures;
    int                    outstanding;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    logic [31:0] cur_origin_x = '0;
    logic [31:0] cur_origin_y = '0;
    logic [30:0] cur_radius   = RADIUS_RESET;
    longint      spot_dx [8];
    longint      spot_dy [8];
    logic [15:0] touched_texels [$];

    const int SENDER_IDLE [4] = '{0, 62, 0, 24};
    const int RECEIVER_STALL [4] = '{0, 0, 62, 24};

    always #5 aclk = ~aclk;

    particle_height_splat_max_top #(
        .TEX_WIDTH (TEX_WIDTH),
        .TEX_HEIGHT(TEX_HEIGHT)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_particle_x (s_particle_x),
        .s_particle_y (s_particle_y),
        .s_particle_z (s_particle_z),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_texel_index(m_texel_index),
        .m_texel_value(m_texel_value)
    );

    height_texel_checker #(
        .TEX_WIDTH (TEX_WIDTH),
        .TEX_HEIGHT(TEX_HEIGHT)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_particle_x (s_particle_x),
        .s_particle_y (s_particle_y),
        .s_particle_z (s_particle_z),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_texel_index(m_texel_index),
        .m_texel_value(m_texel_value),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_valid && m_ready && m_hit) begin
            touched_texels.insert(touched_texels.size(), m_texel_index);
            if (touched_texels.size() > 32)
                void'(touched_texels.pop_front());
        end
    end

    task automatic set_register(logic [1:0] sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (sel)
            REG_ORIGIN_X: cur_origin_x = value;
            REG_ORIGIN_Y: cur_origin_y = value;
            REG_RADIUS:   cur_radius   = value[30:0];
            default: ;
        endcase
    endtask

    task automatic set_area(logic [31:0] ox, logic [31:0] oy, logic [30:0] r);
        set_register(REG_ORIGIN_X, ox);
        set_register(REG_ORIGIN_Y, oy);
        set_register(REG_RADIUS, {1'b0, r});
    endtask

    task automatic send_request(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [15:0] ridx);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_particle_x <= x;
        s_particle_y <= y;
        s_particle_z <= z;
        s_read_index <= ridx;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic splat(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_request(OP_SPLAT, x, y, z, 16'($urandom));
    endtask

    task automatic read_texel(logic [15:0] ridx);
        send_request(OP_READ, $urandom, $urandom, $urandom, ridx);
    endtask

    // idle the request side until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_depth();
        case ($urandom_range(3))
            0:       return -$urandom_range(2700);
            1:       return -$urandom_range(300);
            2:       return $urandom;
            default: return $urandom_range(5000);
        endcase
    endfunction

    task automatic random_request();
        int     roll;
        int     k;
        longint span, offx, offy;
        roll = $urandom_range(99);
        span = longint'(cur_radius) - 1;
        if (roll < 15) begin
            send_request(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                         16'($urandom_range(65535)));
        end else if (roll < 35) begin
            if (touched_texels.size() != 0 && $urandom_range(1))
                read_texel(touched_texels[$urandom_range(touched_texels.size() - 1)]);
            else
                read_texel(16'($urandom_range(65535)));
        end else begin
            if ($urandom_range(99) < 40) begin
                k    = $urandom_range(7);
                offx = spot_dx[k];
                offy = spot_dy[k];
            end else begin
                offx = longint'($urandom_range(32'(2 * span))) - span;
                offy = longint'($urandom_range(32'(2 * span))) - span;
            end
            splat(32'(longint'($signed(cur_origin_x)) + offx),
                  32'(longint'($signed(cur_origin_y)) + offy), random_depth());
        end
    endtask

    initial begin
        logic [30:0] r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: texture edges, the circle boundary, height saturation and max keeping
        idle_pct  = 24;
        stall_pct = 24;
        set_area('0, '0, 31'd1024);
        read_texel(16'd0);
        read_texel(16'hFFFF);
        splat(0, 0, -1024);
        splat(0, 0, -512);
        splat(0, 0, -2048);
        read_texel(16'd32896);
        splat(1023, 0, 0);
        splat(-1023, 0, 32'h7FFF_FFFF);
        splat(0, 1023, 32'h8000_0000);
        splat(0, -1023, -2621);
        splat(5, 5, -2611);
        splat(1024, 0, -1024);
        splat(724, 724, -1024);
        splat(725, 724, -1024);
        splat(32'h8000_0000, 32'h7FFF_FFFF, -1024);
        splat(32'h7FFF_FFFF, 32'h8000_0000, -1024);
        read_texel(16'd33023);

        wait_drained();
        set_area(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        splat(32'h8000_0007, 32'h7FFF_FFF6, -300);
        splat(32'h7FFF_FFFF, 32'h8000_0000, -300);
        splat(-2, 32'h7FFF_FFFF, -50);

        // zero radius: every splat misses
        wait_drained();
        set_area('0, '0, '0);
        splat(0, 0, -1024);
        read_texel(16'd32896);

        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            idle_pct  = SENDER_IDLE[ph % 4];
            stall_pct = RECEIVER_STALL[ph % 4];
            case (ph)
                0:       r = 31'd1024;
                1:       r = 31'h7FFF_FFFF;
                2:       r = 31'd1;
                3:       r = 31'd3;
                4:       r = 31'($urandom_range(4096, 16));
                5:       r = 31'($urandom_range(32'h7FFF_FFFF, 1));
                6:       r = 31'd1 << 20;
                default: r = 31'd200;
            endcase
            if (ph == 0)
                set_area('0, '0, r);
            else if (ph == 1)
                set_area(32'h8000_0000, 32'h7FFF_FFFF, r);
            else
                set_area($urandom, $urandom, r);
            for (int k = 0; k < 8; k++) begin
                spot_dx[k] = longint'($urandom_range(32'(r))) - longint'(r / 2);
                spot_dy[k] = longint'($urandom_range(32'(r))) - longint'(r / 2);
            end
            repeat (115) begin
                if ($urandom_range(99) < 2)
                    wait_drained();
                random_request();
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", outstanding);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/phsm_pkg.sv
rtl/core/phsm_cfg.sv
rtl/core/phsm_front.sv
rtl/core/phsm_queue.sv
rtl/core/phsm_back.sv
rtl/core/particle_height_splat_max_top.sv
verif/height_texel_checker.sv
verif/tb.sv
